/* rtl/core/arq_pkg.sv */
`timescale 1ns / 1ps

package arq_pkg;

   // command codes
   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_PEEK   = 2'd1;
   localparam logic [1:0] CMD_RETIRE = 2'd2;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 3;
   localparam int TAG_W    = 32;
   // destination, type, sequence, result, detail
   localparam int FIELDS_W = 5 * BYTE_W;

   // sequencer to scan unit
   typedef struct packed {
      logic clear;   // new word accepted: drop accumulated scan results
      logic check;   // read data for one entry is on the memory output
   } scan_ctl_type;

   // scan unit to sequencer
   typedef struct packed {
      logic match;    // active entry with the same key
      logic free;     // inactive slot seen
      logic best;     // oldest active entry seen
      logic ret_hit;  // retire slot active with equal stamp
   } scan_stat_type;

endpackage

/* rtl/core/arq_req_if.sv */
`timescale 1ns / 1ps

interface arq_req_if;
   logic                       valid;
   logic                       ready;
   logic [arq_pkg::CMD_W-1:0]  cmd;
   logic [arq_pkg::BYTE_W-1:0] destination;
   logic [arq_pkg::BYTE_W-1:0] request_type;
   logic [arq_pkg::BYTE_W-1:0] request_seq;
   logic [arq_pkg::BYTE_W-1:0] result_code;
   logic [arq_pkg::BYTE_W-1:0] detail;
   logic [arq_pkg::SLOT_W-1:0] slot_index;
   logic [arq_pkg::TAG_W-1:0]  order_tag;

   modport source (
      output valid, cmd, destination, request_type, request_seq, result_code, detail,
             slot_index, order_tag,
      input  ready
   );
   modport sink (
      input  valid, cmd, destination, request_type, request_seq, result_code, detail,
             slot_index, order_tag,
      output ready
   );
endinterface

/* rtl/core/arq_rsp_if.sv */
`timescale 1ns / 1ps

interface arq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic                       merged;
   logic                       evicted;
   logic [arq_pkg::SLOT_W-1:0] slot;
   logic [arq_pkg::TAG_W-1:0]  stamp;
   logic [arq_pkg::BYTE_W-1:0] out_destination;
   logic [arq_pkg::BYTE_W-1:0] out_type;
   logic [arq_pkg::BYTE_W-1:0] out_seq;
   logic [arq_pkg::BYTE_W-1:0] out_result;
   logic [arq_pkg::BYTE_W-1:0] out_detail;

   modport source (
      output valid, found, merged, evicted, slot, stamp, out_destination, out_type,
             out_seq, out_result, out_detail,
      input  ready
   );
   modport sink (
      input  valid, found, merged, evicted, slot, stamp, out_destination, out_type,
             out_seq, out_result, out_detail,
      output ready
   );
endinterface

/* rtl/core/arq_ram.sv */
`timescale 1ns / 1ps

module arq_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/arq_scan.sv */
`timescale 1ns / 1ps

// Accumulates key match, first free slot, oldest active entry and the retire
// check while the sequencer walks the entry memory one word per cycle.
module arq_scan #(
   parameter int DEPTH      = 8,
   parameter int STAMP_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  arq_pkg::scan_ctl_type                    ctl,
   input  logic [$clog2(DEPTH)-1:0]                 chk_idx,
   input  logic [STAMP_BITS+arq_pkg::FIELDS_W-1:0]  rd_data,
   input  logic [DEPTH-1:0]                         active,
   input  logic [arq_pkg::BYTE_W-1:0]               key_dst,
   input  logic [arq_pkg::BYTE_W-1:0]               key_typ,
   input  logic [arq_pkg::BYTE_W-1:0]               key_seq,
   input  logic [arq_pkg::SLOT_W-1:0]               ret_slot,
   input  logic [arq_pkg::TAG_W-1:0]                ret_tag,
   output arq_pkg::scan_stat_type                   stat,
   output logic [$clog2(DEPTH)-1:0]                 match_idx,
   output logic [STAMP_BITS-1:0]                    match_stamp,
   output logic [$clog2(DEPTH)-1:0]                 free_idx,
   output logic [$clog2(DEPTH)-1:0]                 best_idx,
   output logic [STAMP_BITS+arq_pkg::FIELDS_W-1:0]  best_data
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int DATA_W = STAMP_BITS + arq_pkg::FIELDS_W;
   localparam int CMP_W  = IDX_W + arq_pkg::SLOT_W;
   localparam int BW     = arq_pkg::BYTE_W;

   logic [STAMP_BITS-1:0] e_stamp;
   logic [BW-1:0]         e_dst, e_typ, e_seq;
   logic                  e_act;
   logic [STAMP_BITS-1:0] age_diff;
   logic                  e_older;

   logic                  match_ff, match_in;
   logic                  free_ff, free_in;
   logic                  best_ff, best_in;
   logic                  ret_ff, ret_in;
   logic [IDX_W-1:0]      match_idx_ff, match_idx_in;
   logic [STAMP_BITS-1:0] match_stamp_ff, match_stamp_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DATA_W-1:0]     best_data_ff, best_data_in;

   assign e_stamp = rd_data[DATA_W-1 -: STAMP_BITS];
   assign e_dst   = rd_data[5*BW-1 -: BW];
   assign e_typ   = rd_data[4*BW-1 -: BW];
   assign e_seq   = rd_data[3*BW-1 -: BW];
   assign e_act   = active[chk_idx];

   // wrap-around age: older when the difference has its top bit set
   assign age_diff = e_stamp - best_data_ff[DATA_W-1 -: STAMP_BITS];
   assign e_older  = age_diff[STAMP_BITS-1];

   always_comb begin
      match_in       = match_ff;
      free_in        = free_ff;
      best_in        = best_ff;
      ret_in         = ret_ff;
      match_idx_in   = match_idx_ff;
      match_stamp_in = match_stamp_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_data_in   = best_data_ff;
      if (ctl.clear) begin
         match_in = 1'b0;
         free_in  = 1'b0;
         best_in  = 1'b0;
         ret_in   = 1'b0;
      end else if (ctl.check) begin
         if (e_act && !match_ff && e_dst == key_dst && e_typ == key_typ
             && e_seq == key_seq) begin
            match_in       = 1'b1;
            match_idx_in   = chk_idx;
            match_stamp_in = e_stamp;
         end
         if (!e_act && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx;
         end
         // strict compare keeps the lower slot on equal age
         if (e_act && (!best_ff || e_older)) begin
            best_in      = 1'b1;
            best_idx_in  = chk_idx;
            best_data_in = rd_data;
         end
         if (e_act && CMP_W'(chk_idx) == CMP_W'(ret_slot)
             && arq_pkg::TAG_W'(e_stamp) == ret_tag) begin
            ret_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
         best_ff  <= 1'b0;
         ret_ff   <= 1'b0;
      end else begin
         match_ff <= match_in;
         free_ff  <= free_in;
         best_ff  <= best_in;
         ret_ff   <= ret_in;
      end
      match_idx_ff   <= match_idx_in;
      match_stamp_ff <= match_stamp_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_data_ff   <= best_data_in;
   end

   assign stat.match   = match_ff;
   assign stat.free    = free_ff;
   assign stat.best    = best_ff;
   assign stat.ret_hit = ret_ff;
   assign match_idx    = match_idx_ff;
   assign match_stamp  = match_stamp_ff;
   assign free_idx     = free_idx_ff;
   assign best_idx     = best_idx_ff;
   assign best_data    = best_data_ff;

endmodule

/* rtl/core/ack_reply_queue_core.sv */
`timescale 1ns / 1ps

// channel  dir  handshake      word
// req_ch   in   valid/ready    cmd, key, result, detail, retire slot and tag
// rsp_ch   out  valid/ready    flags, slot, stamp, peeked entry fields
//
// Every command walks the entry memory once: one read per cycle, then a drain
// step and the finish step that loads the response; a new word is taken only
// after the finish step of the previous one (ready is high only in idle).
// The single read port of the entry memory sets the pace of the walk.
// Reset is synchronous; it clears the active bits and the stamp counter.
// A new word is taken while the response register still waits; the finish
// step stalls until that register is free.
module ack_reply_queue_core #(
   parameter int DEPTH      = 8,
   parameter int STAMP_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   arq_req_if.sink   req_ch,
   arq_rsp_if.source rsp_ch
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int DATA_W = STAMP_BITS + arq_pkg::FIELDS_W;
   localparam int BW     = arq_pkg::BYTE_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic [DEPTH-1:0]        active_ff, active_in;
   logic [STAMP_BITS-1:0]   next_stamp_ff, next_stamp_in;

   logic [arq_pkg::CMD_W-1:0]  cmd_ff;
   logic [BW-1:0]              dst_ff, typ_ff, seq_ff, res_ff, det_ff;
   logic [arq_pkg::SLOT_W-1:0] ret_slot_ff;
   logic [arq_pkg::TAG_W-1:0]  ret_tag_ff;

   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic                       rsp_merged_ff, rsp_merged_in;
   logic                       rsp_evicted_ff, rsp_evicted_in;
   logic [arq_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [arq_pkg::TAG_W-1:0]  rsp_stamp_ff, rsp_stamp_in;
   logic [arq_pkg::FIELDS_W-1:0] rsp_fields_ff, rsp_fields_in;

   logic                   accept;
   logic                   finish;
   arq_pkg::scan_ctl_type  ctl;
   arq_pkg::scan_stat_type stat;
   logic [IDX_W-1:0]       match_idx, free_idx, best_idx, sel_idx;
   logic [STAMP_BITS-1:0]  match_stamp;
   logic [DATA_W-1:0]      best_data;
   logic [DATA_W-1:0]      rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DATA_W-1:0]      wr_data;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign finish       = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_ch.ready);
   assign ctl.clear    = accept;
   assign ctl.check    = chk_vld_ff;
   // a full table has no free slot: replace the oldest
   assign sel_idx      = stat.free ? free_idx : best_idx;

   arq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   arq_scan #(
      .DEPTH      (DEPTH),
      .STAMP_BITS (STAMP_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .chk_idx     (chk_idx_ff),
      .rd_data     (rd_data),
      .active      (active_ff),
      .key_dst     (dst_ff),
      .key_typ     (typ_ff),
      .key_seq     (seq_ff),
      .ret_slot    (ret_slot_ff),
      .ret_tag     (ret_tag_ff),
      .stat        (stat),
      .match_idx   (match_idx),
      .match_stamp (match_stamp),
      .free_idx    (free_idx),
      .best_idx    (best_idx),
      .best_data   (best_data)
   );

   // sequencer: the check follows the read pointer in the next cycle
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            chk_vld_in = 1'b1;
            if (idx_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // finish step: memory write, active bits, stamp counter, response
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = sel_idx;
      wr_data        = {next_stamp_ff, dst_ff, typ_ff, seq_ff, res_ff, det_ff};
      active_in      = active_ff;
      next_stamp_in  = next_stamp_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ch.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_merged_in  = rsp_merged_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_stamp_in   = rsp_stamp_ff;
      rsp_fields_in  = rsp_fields_ff;
      if (finish) begin
         rsp_vld_in     = 1'b1;
         rsp_found_in   = 1'b0;
         rsp_merged_in  = 1'b0;
         rsp_evicted_in = 1'b0;
         rsp_slot_in    = '0;
         rsp_stamp_in   = '0;
         rsp_fields_in  = '0;
         case (cmd_ff)
            arq_pkg::CMD_PUSH: begin
               wr_en = 1'b1;
               if (stat.match) begin
                  wr_addr       = match_idx;
                  wr_data       = {match_stamp, dst_ff, typ_ff, seq_ff, res_ff, det_ff};
                  rsp_merged_in = 1'b1;
                  rsp_slot_in   = arq_pkg::SLOT_W'(match_idx);
                  rsp_stamp_in  = arq_pkg::TAG_W'(match_stamp);
               end else begin
                  active_in[sel_idx] = 1'b1;
                  next_stamp_in      = next_stamp_ff + 1'b1;
                  rsp_evicted_in     = !stat.free;
                  rsp_slot_in        = arq_pkg::SLOT_W'(sel_idx);
                  rsp_stamp_in       = arq_pkg::TAG_W'(next_stamp_ff);
               end
            end
            arq_pkg::CMD_PEEK: begin
               if (stat.best) begin
                  rsp_found_in  = 1'b1;
                  rsp_slot_in   = arq_pkg::SLOT_W'(best_idx);
                  rsp_stamp_in  = arq_pkg::TAG_W'(best_data[DATA_W-1 -: STAMP_BITS]);
                  rsp_fields_in = best_data[arq_pkg::FIELDS_W-1:0];
               end
            end
            arq_pkg::CMD_RETIRE: begin
               if (stat.ret_hit) begin
                  active_in[IDX_W'(ret_slot_ff)] = 1'b0;
                  rsp_found_in = 1'b1;
               end
            end
            default: begin
               // reserved command: all-zero response
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         active_ff     <= '0;
         next_stamp_ff <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         active_ff     <= active_in;
         next_stamp_ff <= next_stamp_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      idx_ff         <= idx_in;
      chk_idx_ff     <= chk_idx_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_merged_ff  <= rsp_merged_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_stamp_ff   <= rsp_stamp_in;
      rsp_fields_ff  <= rsp_fields_in;
      if (accept) begin
         cmd_ff      <= req_ch.cmd;
         dst_ff      <= req_ch.destination;
         typ_ff      <= req_ch.request_type;
         seq_ff      <= req_ch.request_seq;
         res_ff      <= req_ch.result_code;
         det_ff      <= req_ch.detail;
         ret_slot_ff <= req_ch.slot_index;
         ret_tag_ff  <= req_ch.order_tag;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.found           = rsp_found_ff;
   assign rsp_ch.merged          = rsp_merged_ff;
   assign rsp_ch.evicted         = rsp_evicted_ff;
   assign rsp_ch.slot            = rsp_slot_ff;
   assign rsp_ch.stamp           = rsp_stamp_ff;
   assign rsp_ch.out_destination = rsp_fields_ff[5*BW-1 -: BW];
   assign rsp_ch.out_type        = rsp_fields_ff[4*BW-1 -: BW];
   assign rsp_ch.out_seq         = rsp_fields_ff[3*BW-1 -: BW];
   assign rsp_ch.out_result      = rsp_fields_ff[2*BW-1 -: BW];
   assign rsp_ch.out_detail      = rsp_fields_ff[BW-1:0];

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response loaded outside the finish step");

   a_stamp_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      (next_stamp_ff != $past(next_stamp_ff)) |->
         ($past(finish) && $past(cmd_ff) == arq_pkg::CMD_PUSH && !$past(stat.match)))
      else $error("stamp counter moved without an insert");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (finish && cmd_ff == arq_pkg::CMD_PUSH && !stat.match && !stat.free)
         |-> (&active_ff))
      else $error("eviction while a slot is free");

   a_merge_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_merged_ff && rsp_evicted_ff))
      else $error("merge and eviction in one response");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("entry check outside the memory walk");

endmodule
